>>> sv/lswq_pkg.sv
package lswq_pkg;

    localparam int OP_W   = 3;
    localparam int SLOT_W = 6;
    localparam int KIND_W = 8;
    localparam int ST_W   = 2;

    localparam logic [OP_W-1:0] OP_APPEND  = 3'd0;
    localparam logic [OP_W-1:0] OP_REMOVE  = 3'd1;
    localparam logic [OP_W-1:0] OP_SETKIND = 3'd2;
    localparam logic [OP_W-1:0] OP_FIRST   = 3'd3;
    localparam logic [OP_W-1:0] OP_NEXT    = 3'd4;

    localparam logic [ST_W-1:0] ST_OK         = 2'd0;
    localparam logic [ST_W-1:0] ST_NOT_QUEUED = 2'd1;
    localparam logic [ST_W-1:0] ST_ALREADY    = 2'd2;

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_EXEC  = 4'b0100,
        S_LINK  = 4'b1000
    } t_state;

endpackage

>>> sv/lswq_ram.sv
module lswq_ram
    import lswq_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int WIDTH = 7,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/linked_slot_wait_queue.sv
// channel | direction | handshake          | payload
// input   | in        | i_valid / o_stall  | i_opcode, i_slot, i_kind
// result  | out       | o_valid / i_stall  | o_result_slot, o_found, o_status
//
// a stored append: accept, execute, tail link write; other opcodes and a refused append:
// accept, execute; the single write port of the next-link ram sets the extra append step
// after reset a clearing pass over every slot zeroes the used bits, o_stall is high meanwhile
// a result waits in the output register; an item may be accepted while it waits, and its
// execute step holds until the output register is free
module linked_slot_wait_queue
    import lswq_pkg::*;
#(
    parameter int SLOTS = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [OP_W-1:0]   i_opcode,
    input  logic [SLOT_W-1:0] i_slot,
    input  logic [KIND_W-1:0] i_kind,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [SLOT_W-1:0] o_result_slot,
    output logic              o_found,
    output logic [ST_W-1:0]   o_status
);

    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int LW = $clog2(SLOTS + 1);
    localparam logic [LW-1:0] NONE = LW'(SLOTS);

    t_state r_state, n_state;
    logic [AW-1:0]     r_clr_cnt, n_clr_cnt;
    logic [OP_W-1:0]   r_op;
    logic [SLOT_W-1:0] r_slot;
    logic [KIND_W-1:0] r_kind;
    logic [LW-1:0]     r_head, n_head;
    logic [LW-1:0]     r_tail, n_tail;
    logic              r_out_valid, n_out_valid;
    logic [SLOT_W-1:0] r_out_slot, n_out_slot;
    logic              r_out_found, n_out_found;
    logic [ST_W-1:0]   r_out_status, n_out_status;

    logic [KIND_W-1:0] r_kind_mem [SLOTS];

    logic          w_accept;
    logic [AW-1:0] w_slot_addr;
    logic [AW-1:0] w_rd_addr;
    logic          w_in_range;
    logic          w_queued;
    logic          w_out_free;

    logic          w_used_rd;
    logic [LW-1:0] w_prev_rd;
    logic [LW-1:0] w_next_rd;

    logic          w_used_we, w_used_wd;
    logic [AW-1:0] w_used_wa;
    logic          w_prev_we;
    logic [AW-1:0] w_prev_wa;
    logic [LW-1:0] w_prev_wd;
    logic          w_next_we;
    logic [AW-1:0] w_next_wa;
    logic [LW-1:0] w_next_wd;
    logic          w_kind_we;

    assign o_stall    = (r_state != S_IDLE);
    assign w_accept   = i_valid && !o_stall;
    assign w_slot_addr = AW'(r_slot);
    assign w_rd_addr  = (r_state == S_IDLE) ? AW'(i_slot) : w_slot_addr;
    assign w_in_range = (32'(r_slot) < SLOTS);
    assign w_queued   = w_in_range && w_used_rd;
    assign w_out_free = !r_out_valid || !i_stall;

    lswq_ram #(.DEPTH(SLOTS), .WIDTH(1), .AW(AW)) u_used_ram (
        .i_clk   (i_clk),
        .i_we    (w_used_we),
        .i_waddr (w_used_wa),
        .i_wdata (w_used_wd),
        .i_raddr (w_rd_addr),
        .o_rdata (w_used_rd)
    );

    lswq_ram #(.DEPTH(SLOTS), .WIDTH(LW), .AW(AW)) u_prev_ram (
        .i_clk   (i_clk),
        .i_we    (w_prev_we),
        .i_waddr (w_prev_wa),
        .i_wdata (w_prev_wd),
        .i_raddr (w_rd_addr),
        .o_rdata (w_prev_rd)
    );

    lswq_ram #(.DEPTH(SLOTS), .WIDTH(LW), .AW(AW)) u_next_ram (
        .i_clk   (i_clk),
        .i_we    (w_next_we),
        .i_waddr (w_next_wa),
        .i_wdata (w_next_wd),
        .i_raddr (w_rd_addr),
        .o_rdata (w_next_rd)
    );

    // kind is stored per slot but never read back at the outputs
    always_ff @(posedge i_clk) begin
        if (w_kind_we) begin
            r_kind_mem[w_slot_addr] <= r_kind;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_clr_cnt    = r_clr_cnt;
        n_head       = r_head;
        n_tail       = r_tail;
        n_out_valid  = r_out_valid && i_stall;
        n_out_slot   = r_out_slot;
        n_out_found  = r_out_found;
        n_out_status = r_out_status;
        w_used_we    = 1'b0;
        w_used_wa    = w_slot_addr;
        w_used_wd    = 1'b0;
        w_prev_we    = 1'b0;
        w_prev_wa    = w_slot_addr;
        w_prev_wd    = r_tail;
        w_next_we    = 1'b0;
        w_next_wa    = w_slot_addr;
        w_next_wd    = NONE;
        w_kind_we    = 1'b0;

        case (r_state)
            S_CLEAR: begin
                w_used_we = 1'b1;
                w_used_wa = r_clr_cnt;
                n_clr_cnt = r_clr_cnt + AW'(1);
                if (r_clr_cnt == AW'(SLOTS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (w_out_free) begin
                    n_state      = S_IDLE;
                    n_out_valid  = 1'b1;
                    n_out_slot   = '0;
                    n_out_found  = 1'b0;
                    n_out_status = ST_OK;
                    case (r_op)
                        OP_APPEND: begin
                            if (!w_in_range) begin
                                n_out_status = ST_NOT_QUEUED;
                            end else if (w_used_rd) begin
                                n_out_status = ST_ALREADY;
                            end else begin
                                w_used_we = 1'b1;
                                w_used_wd = 1'b1;
                                w_prev_we = 1'b1;
                                w_kind_we = 1'b1;
                                // old tail points forward here, own next link next cycle
                                if (r_tail != NONE) begin
                                    w_next_we = 1'b1;
                                    w_next_wa = AW'(r_tail);
                                    w_next_wd = LW'(r_slot);
                                end else begin
                                    n_head = LW'(r_slot);
                                end
                                n_tail  = LW'(r_slot);
                                n_state = S_LINK;
                            end
                        end
                        OP_REMOVE: begin
                            if (!w_queued) begin
                                n_out_status = ST_NOT_QUEUED;
                            end else begin
                                w_used_we = 1'b1;
                                if (w_prev_rd != NONE) begin
                                    w_next_we = 1'b1;
                                    w_next_wa = AW'(w_prev_rd);
                                    w_next_wd = w_next_rd;
                                end else begin
                                    n_head = w_next_rd;
                                end
                                if (w_next_rd != NONE) begin
                                    w_prev_we = 1'b1;
                                    w_prev_wa = AW'(w_next_rd);
                                    w_prev_wd = w_prev_rd;
                                end else begin
                                    n_tail = w_prev_rd;
                                end
                            end
                        end
                        OP_SETKIND: begin
                            if (!w_queued) begin
                                n_out_status = ST_NOT_QUEUED;
                            end else begin
                                w_kind_we = 1'b1;
                            end
                        end
                        OP_FIRST: begin
                            if (r_head != NONE) begin
                                n_out_found = 1'b1;
                                n_out_slot  = SLOT_W'(r_head);
                            end
                        end
                        OP_NEXT: begin
                            if (!w_queued) begin
                                n_out_status = ST_NOT_QUEUED;
                            end else if (w_next_rd != NONE) begin
                                n_out_found = 1'b1;
                                n_out_slot  = SLOT_W'(w_next_rd);
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_LINK: begin
                w_next_we = 1'b1;
                n_state   = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_cnt   <= '0;
            r_head      <= NONE;
            r_tail      <= NONE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_cnt   <= n_clr_cnt;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op   <= i_opcode;
            r_slot <= i_slot;
            r_kind <= i_kind;
        end
        r_out_slot   <= n_out_slot;
        r_out_found  <= n_out_found;
        r_out_status <= n_out_status;
    end

    assign o_valid       = r_out_valid;
    assign o_result_slot = r_out_slot;
    assign o_found       = r_out_found;
    assign o_status      = r_out_status;

    // empty queue has neither head nor tail
    a_head_tail_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_head == NONE) == (r_tail == NONE))
        else $error("head and tail disagree on empty queue");

    a_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_found) |-> (o_result_slot == '0))
        else $error("result slot nonzero without found");

    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_found) |-> (o_status == ST_OK))
        else $error("found with error status");

    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_EXEC))
        else $error("accepted transfer not executed");

    a_idle_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (!w_used_we && !w_prev_we && !w_next_we && !w_kind_we))
        else $error("storage written while idle");

endmodule
